>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame parser.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/lpfp_pkg.sv
// Shared types and constants of the length-prefixed frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hEE;
    localparam logic [7:0] SYNC_SECOND = 8'hEF;
    localparam logic [7:0] FRAME_TAIL  = 8'hFF;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DATA = 2'd1,
        EV_DONE = 2'd2,
        EV_DROP = 2'd3
    } event_t;

    // one received byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } in_word_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic [7:0] frame_check;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/length_prefixed_frame_parser_core.sv
// Channel   Dir  Data                                         Side band
// s_        in   tdata[7:0] rx_byte                           -
// m_        out  tdata[39:0] byte, index, type, length, check tuser[1:0] event
//
// One byte per cycle sustained while m_ is not stalled; a byte's result passes
// the input register, then the result register, before it shows on m_.
// Synchronous active-low reset returns the parser to waiting for the first
// start byte with type, length, count and checksum cleared.
// A stalled m_ holds the result and the input register keeps one more byte;
// s_tready then drops until the result is taken.
`default_nettype none

`include "assert_macros.svh"

module length_prefixed_frame_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [1:0]       m_tuser,   // [1:0] event_res
    output logic [39:0]      m_tdata    // [7:0] payload_byte, [15:8] payload_index,
                                        // [23:16] frame_type, [31:24] frame_length,
                                        // [39:32] frame_check
);
    import lpfp_pkg::*;

    in_word_t in_word;
    result_t  result;
    logic     advance;

    lpfp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .word_o   (in_word)
    );

    lpfp_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .word_i   (in_word),
        .advance  (advance),
        .result_o (result)
    );

    lpfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_word.valid),
        .result_i (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // a payload word always lies inside the declared length
    `ASSERT_IMPLY(a_index_in_range, aclk, aresetn,
        m_tvalid && (m_tuser == EV_DATA), m_tdata[15:8] < m_tdata[31:24])
    // checksum only shows on a completed frame
    `ASSERT_IMPLY(a_check_only_done, aclk, aresetn,
        m_tvalid && (m_tuser != EV_DONE), m_tdata[39:32] == 8'd0)
    // payload fields are zero unless a payload word is reported
    `ASSERT_IMPLY(a_payload_only_data, aclk, aresetn,
        m_tvalid && (m_tuser != EV_DATA), m_tdata[15:0] == 16'd0)
    // the parser only steps on a held input byte
    `ASSERT_ALWAYS(a_advance_needs_word, aclk, aresetn, !advance || in_word.valid)

endmodule

`default_nettype wire

>>> rtl/lpfp_in_stage.sv
// Input register of the frame parser: holds one received byte.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               advance,
    output lpfp_pkg::in_word_t      word_o
);
    import lpfp_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;

    // a new word may enter when the slot is empty or drains this cycle
    assign s_tready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign word_o.valid = valid_reg;
    assign word_o.data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/lpfp_parse.sv
// Frame state machine: tracks sync, header, payload, checksum and tail bytes.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_parse (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lpfp_pkg::in_word_t word_i,
    input  wire logic               advance,
    output lpfp_pkg::result_t       result_o
);
    import lpfp_pkg::*;

    typedef enum logic [2:0] {
        PH_START0 = 3'd0,
        PH_START1 = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LENGTH = 3'd3,
        PH_DATA   = 3'd4,
        PH_CHECK  = 3'd5,
        PH_END    = 3'd6
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [7:0] type_reg,   type_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg,  count_next;
    logic [7:0] check_reg,  check_next;

    logic [7:0] b;
    logic       clear_after;
    result_t    res;

    assign b = word_i.data;

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        check_next  = check_reg;
        clear_after = 1'b0;

        res.event_res     = EV_NONE;
        res.payload_byte  = 8'd0;
        res.payload_index = 8'd0;
        res.frame_check   = 8'd0;

        unique case (phase_reg)
            PH_START1: begin
                if (b == SYNC_SECOND) begin
                    phase_next = PH_TYPE;
                end else begin
                    res.event_res = EV_DROP;
                    clear_after   = 1'b1;
                end
            end
            PH_TYPE: begin
                type_next  = b;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH: begin
                length_next = b;
                count_next  = 8'd0;
                phase_next  = (b != 8'd0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                res.event_res     = EV_DATA;
                res.payload_byte  = b;
                res.payload_index = count_reg;
                count_next        = count_reg + 8'd1;
                if (count_next >= length_reg) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                check_next = b;
                phase_next = PH_END;
            end
            PH_END: begin
                if (b == FRAME_TAIL) begin
                    res.event_res   = EV_DONE;
                    res.frame_check = check_reg;
                end else begin
                    res.event_res = EV_DROP;
                end
                clear_after = 1'b1;
            end
            default: begin
                // start0 and the unused code
                phase_next = (b == SYNC_FIRST) ? PH_START1 : PH_START0;
            end
        endcase

        // reported values are taken before the frame is cleared
        res.frame_type   = type_next;
        res.frame_length = length_next;

        if (clear_after) begin
            phase_next  = PH_START0;
            type_next   = 8'd0;
            length_next = 8'd0;
            count_next  = 8'd0;
            check_next  = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START0;
            type_reg   <= 8'd0;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            check_reg  <= 8'd0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            check_reg  <= check_next;
        end
    end

    assign result_o = res;

endmodule

`default_nettype wire

>>> rtl/lpfp_out_reg.sv
// Result register of the frame parser: drives the master-side stream.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire lpfp_pkg::result_t result_i,
    output logic                   advance,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [1:0]             m_tuser,
    output logic [39:0]            m_tdata
);
    import lpfp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // the register takes a word when empty or being emptied
    assign advance = in_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= result_i;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = {res_reg.frame_check, res_reg.frame_length, res_reg.frame_type,
                       res_reg.payload_index, res_reg.payload_byte};

endmodule

`default_nettype wire

>>> sim/length_prefixed_frame_parser_core_tb.sv
`timescale 1ns / 100ps
// Testbench for length_prefixed_frame_parser_core: streams bytes into s_ and checks
// every m_ word against a byte-level model of the frame parser held in a scoreboard.
// Depends on lpfp_pkg and the core RTL only.

module length_prefixed_frame_parser_core_tb;
    import lpfp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_BYTES = 1050;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_TYPE  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5,
        PH_TAIL  = 3'd6
    } parse_phase_t;

    class frame_event_checker;
        parse_phase_t phase;
        logic [7:0]   type_q;
        logic [7:0]   len_q;
        logic [7:0]   count_q;
        logic [7:0]   check_q;
        result_t      pending_events[$];
        int           mismatches;

        function new();
            clear_frame();
            mismatches = 0;
        endfunction

        function void clear_frame();
            phase   = PH_IDLE;
            type_q  = '0;
            len_q   = '0;
            count_q = '0;
            check_q = '0;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        // every accepted byte yields exactly one event word
        function void take_rx_byte(logic [7:0] b);
            result_t r;
            logic    wipe;
            r = '0;
            r.event_res = EV_NONE;
            wipe = 1'b0;
            case (phase)
                PH_SYNC1: begin
                    if (b == SYNC_SECOND) begin
                        phase = PH_TYPE;
                    end else begin
                        r.event_res = EV_DROP;
                        wipe = 1'b1;
                    end
                end
                PH_TYPE: begin
                    type_q = b;
                    phase  = PH_LEN;
                end
                PH_LEN: begin
                    len_q   = b;
                    count_q = '0;
                    phase   = (b != 8'd0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA: begin
                    r.event_res     = EV_DATA;
                    r.payload_byte  = b;
                    r.payload_index = count_q;
                    count_q         = count_q + 8'd1;
                    if (count_q >= len_q)
                        phase = PH_CHECK;
                end
                PH_CHECK: begin
                    check_q = b;
                    phase   = PH_TAIL;
                end
                PH_TAIL: begin
                    if (b == FRAME_TAIL) begin
                        r.event_res   = EV_DONE;
                        r.frame_check = check_q;
                    end else begin
                        r.event_res = EV_DROP;
                    end
                    wipe = 1'b1;
                end
                default: begin
                    phase = (b == SYNC_FIRST) ? PH_SYNC1 : PH_IDLE;
                end
            endcase
            // type and length as held before any clear
            r.frame_type   = type_q;
            r.frame_length = len_q;
            pending_events.push_back(r);
            if (wipe)
                clear_frame();
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task cmp_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %02h want %02h", name, got, want));
        endtask

        task check_event_word(logic [1:0] user, logic [39:0] data);
            result_t want;
            if (pending_events.size() == 0) begin
                report($sformatf("word %02h/%010h with nothing expected", user, data));
                return;
            end
            want = pending_events.pop_front();
            if (user !== want.event_res)
                report($sformatf("event got %0d want %0d", user, want.event_res));
            cmp_field("payload_byte", data[7:0], want.payload_byte);
            cmp_field("payload_index", data[15:8], want.payload_index);
            cmp_field("frame_type", data[23:16], want.frame_type);
            cmp_field("frame_length", data[31:24], want.frame_length);
            cmp_field("frame_check", data[39:32], want.frame_check);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [39:0] m_tdata;

    frame_event_checker frame_chk = new();
    int   stall_cycles = 0;
    int   bytes_sent   = 0;
    logic steady       = 1'b0;

    length_prefixed_frame_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly no gap, some short ones, a few long; none in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom);
        return (b == avoid) ? ~avoid : b;
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(input int len_pick);
        int         kind;
        int         len;
        int         cut;
        logic [7:0] ty;
        kind = $urandom_range(99);
        if ($urandom_range(15) == 0)
            steady = ~steady;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(byte_other_than(SYNC_FIRST));
        if (len_pick >= 0) begin
            len = len_pick;
        end else begin
            cut = $urandom_range(199);
            if (cut < 12)
                len = 0;
            else if (cut < 197)
                len = $urandom_range(1, 12);
            else
                len = $urandom_range(200, 255);
        end
        ty = 8'($urandom);
        push_byte(SYNC_FIRST);
        if (kind >= 80 && kind < 86) begin
            // broken second sync byte
            push_byte(byte_other_than(SYNC_SECOND));
            return;
        end
        push_byte(SYNC_SECOND);
        push_byte(ty);
        push_byte(len[7:0]);
        if (kind >= 92 && kind < 97) begin
            // truncated frame: following bytes land mid-frame
            cut = $urandom_range(0, len);
            repeat (cut) push_byte(8'($urandom));
            return;
        end
        repeat (len) push_byte(8'($urandom));
        push_byte(8'($urandom));
        if (kind >= 86 && kind < 92)
            push_byte(byte_other_than(FRAME_TAIL));
        else
            push_byte(FRAME_TAIL);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                frame_chk.take_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
                frame_chk.check_event_word(m_tuser, m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    // result side back-pressure
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    end

    initial begin
        logic [7:0] directed [25];
        directed = '{
            8'h00, 8'hFF,                                   // noise while idle
            SYNC_FIRST, SYNC_FIRST,                         // bad second sync
            SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'hAB, FRAME_TAIL,  // empty payload
            SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h5A,
            8'h00,                                          // bad tail byte
            SYNC_FIRST, SYNC_SECOND, 8'h7E, 8'h01, 8'hC3, 8'hFF, FRAME_TAIL
        };
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed[i])
            push_byte(directed[i]);

        bytes_sent = 0;
        send_frame(255);    // full-size payload, index reaches 254
        while (bytes_sent < RANDOM_BYTES)
            send_frame(-1);
        s_tvalid = 1'b0;

        while (frame_chk.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (frame_chk.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/lpfp_pkg.sv
rtl/lpfp_in_stage.sv
rtl/lpfp_parse.sv
rtl/lpfp_out_reg.sv
rtl/length_prefixed_frame_parser_core.sv
sim/length_prefixed_frame_parser_core_tb.sv
